/* rtl/wgm_pkg.sv */
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Shared constants, register indexes and the per-position pattern class type.
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_CFG_W  = 6;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CHARS_PER_WORD = CFG_DATA_W / CHAR_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_5 = 3'd6;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  // Decoded class of one pattern character
  typedef struct packed {
    logic              star;
    logic              quest;
    logic              slash;
    logic [CHAR_W-1:0] folded;
  } pos_class_t;

  // Fold lower-case ASCII letters to upper case, leave everything else
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_slash(input logic [CHAR_W-1:0] c);
    return (c == CH_SLASH) || (c == CH_BSLASH);
  endfunction

  function automatic pos_class_t decode_char(input logic [CHAR_W-1:0] c);
    pos_class_t r;
    r.star   = (c == CH_STAR);
    r.quest  = (c == CH_QUEST);
    r.slash  = is_slash(c);
    r.folded = fold_char(c);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/wgm_pattern_regs.sv */
// ----------------------------------------------------------------------------
// Wildcard glob matcher pattern registers
// Holds the saturated pattern length and the decoded class of each pattern
// position, updated by the configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_pattern_regs #(
  parameter int unsigned MaxPattern = 48,
  parameter int unsigned LenW       = $clog2(MaxPattern + 1)
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [wgm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [wgm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [LenW-1:0]                   len_o,
  output wgm_pkg::pos_class_t               cls_o [MaxPattern],
  output logic                              rearm_o
);
  import wgm_pkg::*;

  localparam pos_class_t ZeroClass = '{star: 1'b0, quest: 1'b0, slash: 1'b0,
                                       folded: '0};

  logic [LenW-1:0]          len_q, len_d;
  logic [LEN_CFG_W-1:0]     len_raw;

  // Any write to a defined register re-arms the matcher
  assign rearm_o = cfg_we_i && (cfg_idx_i <= CFG_PATTERN_WORD_5);

  // Saturate the length to the pattern capacity
  always_comb begin
    len_raw = cfg_data_i[LEN_CFG_W-1:0];
    len_d   = len_q;
    if (cfg_we_i && cfg_idx_i == CFG_PATTERN_LENGTH) begin
      if (len_raw > LEN_CFG_W'(MaxPattern)) begin
        len_d = LenW'(MaxPattern);
      end else begin
        len_d = len_raw[LenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  assign len_o = len_q;

  // Decode each byte as its word is written
  for (genvar p = 0; p < MaxPattern; p++) begin : g_pos
    localparam logic [CFG_IDX_W-1:0] WordIdx =
      CFG_IDX_W'(CFG_PATTERN_WORD_0 + p / CHARS_PER_WORD);
    localparam int unsigned ByteLsb = (p % CHARS_PER_WORD) * CHAR_W;

    pos_class_t cls_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cls_q <= decode_char(ZeroClass.folded);
      end else if (cfg_we_i && cfg_idx_i == WordIdx) begin
        cls_q <= decode_char(cfg_data_i[ByteLsb +: CHAR_W]);
      end
    end

    assign cls_o[p] = cls_q;
  end

endmodule

`default_nettype wire

/* rtl/wgm_step.sv */
// ----------------------------------------------------------------------------
// Wildcard glob matcher position update
// Advances the live position vector by one text byte and forms the match
// result of the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_step #(
  parameter int unsigned MaxPattern = 48,
  parameter int unsigned LenW       = $clog2(MaxPattern + 1)
) (
  input  wire  [MaxPattern:0]               live_i,
  input  wire                               tail_i,
  input  wire  [wgm_pkg::CHAR_W-1:0]        char_i,
  input  wire  [LenW-1:0]                   len_i,
  input  wgm_pkg::pos_class_t               cls_i [MaxPattern],
  output logic [MaxPattern:0]               live_o,
  output logic                              tail_o,
  output logic                              matched_o
);
  import wgm_pkg::*;

  localparam int unsigned W      = MaxPattern + 1;
  localparam int unsigned Levels = $clog2(W);

  logic                slash_t;
  logic [CHAR_W-1:0]   fold_t;
  logic [W-1:0]        skip_p;
  logic [W-1:0]        gen_lvl [Levels+1];
  logic [W-1:0]        prop_lvl [Levels+1];
  logic [W-1:0]        cur;
  logic [MaxPattern-1:0] adv;
  logic [MaxPattern-1:0] stay;
  logic [MaxPattern-1:0] tail_hit;

  assign slash_t = is_slash(char_i);
  assign fold_t  = fold_char(char_i);

  // Result of the state as it stands
  assign matched_o = (len_i == '0) || live_i[len_i] || tail_i;

  // Mark where a non-final star may be skipped before this byte
  always_comb begin
    skip_p = '0;
    for (int j = 0; j < MaxPattern - 1; j++) begin
      skip_p[j+1] = cls_i[j].star && (len_i > LenW'(j + 1)) && !slash_t;
    end
  end

  // Propagate liveness through runs of skippable stars (parallel prefix)
  always_comb begin
    gen_lvl[0]  = live_i;
    prop_lvl[0] = skip_p;
    for (int l = 0; l < Levels; l++) begin
      for (int i = 0; i < W; i++) begin
        if (i >= (1 << l)) begin
          gen_lvl[l+1][i]  = gen_lvl[l][i] | (prop_lvl[l][i] & gen_lvl[l][i-(1<<l)]);
          prop_lvl[l+1][i] = prop_lvl[l][i] & prop_lvl[l][i-(1<<l)];
        end else begin
          gen_lvl[l+1][i]  = gen_lvl[l][i];
          prop_lvl[l+1][i] = prop_lvl[l][i];
        end
      end
    end
    cur = gen_lvl[Levels];
  end

  // Evaluate every pattern position against the byte
  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      logic active;
      logic lit_hit;
      active  = cur[j] && (len_i > LenW'(j));
      lit_hit = (slash_t && cls_i[j].slash) || (fold_t == cls_i[j].folded);
      adv[j]      = active && !cls_i[j].star && (cls_i[j].quest || lit_hit);
      stay[j]     = active && cls_i[j].star && !slash_t && (len_i != LenW'(j + 1));
      tail_hit[j] = active && cls_i[j].star && !slash_t && (len_i == LenW'(j + 1));
    end
  end

  assign live_o = {adv, 1'b0} | {1'b0, stay};
  assign tail_o = (|tail_hit) || (tail_i && !slash_t);

endmodule

`default_nettype wire

/* rtl/wildcard_glob_matcher.sv */
// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Streams text bytes against a configured '*' / '?' pattern and returns one
// match flag per string.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle, text byte or end marker,
// with no gaps unless the output stalls. A transaction is held in an input
// register while the live-position vector of the pattern is advanced in a
// single pass through the step logic; the match flag of a string is formed
// from the input register and registered at the output. A stalled output
// holds back an end marker that would need the output register, and the
// input behind it; a held text byte never waits on the output. A configuration
// write re-arms the matcher and must be made while no string is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher #(
  parameter int unsigned MaxPattern = 48
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Input stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [7:0]                        s_axis_tdata,  // [7:0] text_char
  input  wire                               s_axis_tuser,  // [0] kind
  // Result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [0] matched, [7:1] zero
  // Configuration write port
  input  wire                               cfg_we_i,
  input  wire  [wgm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [wgm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import wgm_pkg::*;

  localparam int unsigned LenW = $clog2(MaxPattern + 1);
  localparam int unsigned W    = MaxPattern + 1;

  logic              in_vld_q, in_vld_d;
  logic              in_kind_q;
  logic [CHAR_W-1:0] in_char_q;
  logic [W-1:0]      live_q, live_d;
  logic              tail_q, tail_d;
  logic              out_vld_q, out_vld_d;
  logic              out_match_q, out_match_d;

  logic              accept;
  logic              proceed;
  logic              rearm;
  logic [LenW-1:0]   len;
  pos_class_t        cls [MaxPattern];
  logic [W-1:0]      step_live;
  logic              step_tail;
  logic              step_matched;

  // Pattern storage
  wgm_pattern_regs #(
    .MaxPattern (MaxPattern),
    .LenW       (LenW)
  ) u_pattern (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .len_o      (len),
    .cls_o      (cls),
    .rearm_o    (rearm)
  );

  // Position update
  wgm_step #(
    .MaxPattern (MaxPattern),
    .LenW       (LenW)
  ) u_step (
    .live_i    (live_q),
    .tail_i    (tail_q),
    .char_i    (in_char_q),
    .len_i     (len),
    .cls_i     (cls),
    .live_o    (step_live),
    .tail_o    (step_tail),
    .matched_o (step_matched)
  );

  // Retire the held transaction unless an end marker finds the output full
  assign proceed       = in_vld_q && (!in_kind_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proceed;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = accept || (in_vld_q && !proceed);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_kind_q <= s_axis_tuser;
      in_char_q <= s_axis_tdata;
    end
  end

  // Advance state, re-arm on end marker or configuration write
  always_comb begin
    live_d      = live_q;
    tail_d      = tail_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_match_d = out_match_q;
    if (rearm) begin
      live_d = W'(1);
      tail_d = 1'b0;
    end else if (proceed) begin
      if (in_kind_q) begin
        live_d      = W'(1);
        tail_d      = 1'b0;
        out_vld_d   = 1'b1;
        out_match_d = step_matched;
      end else begin
        live_d = step_live;
        tail_d = step_tail;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= W'(1);
      tail_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      live_q    <= live_d;
      tail_q    <= tail_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_match_q <= out_match_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_match_q};

  // An end marker leaves the matcher re-armed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proceed && in_kind_q |=> live_q == W'(1) && !tail_q)
    else $error("matcher not re-armed after end marker");

  // No position beyond the pattern end is ever live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q >> len) <= W'(1))
    else $error("live position beyond pattern length");

  // A held transaction stays put until it retires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !proceed |=> in_vld_q && $stable(in_kind_q) && $stable(in_char_q))
    else $error("held transaction lost or altered");

  // A result only appears after an end marker retires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(proceed && in_kind_q))
    else $error("result without end marker");

endmodule

`default_nettype wire
